[sv/hkf_pkg.sv]
// shared types, constants and saturating helpers for the height fusion filter
package hkf_pkg;

  localparam int COV_FRAC = 24;
  localparam int IDX_W    = 3;

  // register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_TERRAIN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_GATE     = 3'd1;
  localparam logic [IDX_W-1:0] REG_INIT     = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN      = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX      = 3'd4;
  localparam logic [IDX_W-1:0] REG_STEP     = 3'd5;

  localparam logic [23:0]        GATE_RST  = 24'd196608;
  localparam logic signed [31:0] MIN_RST   = -32'sd32768000;
  localparam logic signed [31:0] MAX_RST   = 32'sd1310720000;
  localparam logic [23:0]        STEP_RST  = 24'd6554;

  // covariance constants, 24 fraction bits
  localparam logic signed [63:0] COV_INIT_H = 64'sd1000000 <<< COV_FRAC;
  localparam logic signed [63:0] COV_INIT_V = 64'sd100 <<< COV_FRAC;
  localparam logic signed [63:0] PROC_NOISE = 64'sd1677722;

  localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {OP_RAW, OP_SH, OP_DIV} op_mode_t;

  // measurement noise per sensor: 4.0, 1.0, 2.25
  function automatic logic signed [63:0] meas_noise(input logic [1:0] idx);
    logic signed [63:0] r;
    case (idx)
      2'd0: r = 64'sd67108864;
      2'd1: r = 64'sd16777216;
      2'd2: r = 64'sd37748736;
      default: r = 64'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
    if (x > 65'sd2147483647) return 32'sh7fff_ffff;
    if (x < -65'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

endpackage

[sv/height_kalman_fusion.sv]
// two-state height and velocity filter fusing gps and two altimeters
// Usage: one input transfer on in_* carries the three readings of a step.
// The block predicts height, velocity and covariance over step_time, then
// fuses gps (terrain removed), altimeter 1 and altimeter 2 in that order,
// skipping readings outside the valid window or failing the residual gate.
// One result transfer on out_* follows each input: the fused height and
// the used, invalid and outlier masks.
// All products and quotients run on one shared unit: a 64x16 multiplier
// that works top slice first and a radix-2 divider. A prediction uses
// four scaled products and a fused reading five divisions; a reading
// outside the window skips the unit and one that fails the gate stops
// after its gate products. in_tready is high only while the block is idle.
// A finished result waits in the output register; the next item is taken
// meanwhile, and the block holds its new result until out_tready frees it.
// Configuration is written through cfg_* while idle; writing initial_height
// reloads the filter state. Reset (rst_n low, synchronous) restores the
// configuration, filter and sequencer registers and empties the output register.
module height_kalman_fusion
  import hkf_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int COV_WIDTH = 56
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [95:0]       in_tdata,   // gps_altitude, alt1_height, alt2_height
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // fused height, used_mask, invalid_mask,
                                        // outlier_mask, zero fill
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam logic signed [63:0] COV_MAX = (64'sd1 <<< (COV_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] COV_MIN = -COV_MAX - 64'sd1;
  localparam logic [127:0]       SH_RND  = 128'd1 << (FRAC_BITS - 1);

  function automatic logic signed [COV_WIDTH-1:0] satcov(input logic signed [63:0] x);
    if (x > COV_MAX) return COV_MAX[COV_WIDTH-1:0];
    if (x < COV_MIN) return COV_MIN[COV_WIDTH-1:0];
    return x[COV_WIDTH-1:0];
  endfunction

  typedef enum logic [4:0] {
    S_IDLE, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
    S_CHK, S_G1, S_G2, S_G3, S_U1, S_U2, S_U3, S_U4, S_U5,
    S_NEXT, S_WAIT, S_OUT
  } state_t;

  typedef enum logic [2:0] {U_IDLE, U_MUL, U_RND, U_DIV, U_FIN} u_state_t;

  // configuration
  logic signed [31:0] terrain_r, min_r, max_r;
  logic [23:0]        gate_r, step_r;

  // filter state
  logic signed [31:0]          h_r, v_r;
  logic signed [COV_WIDTH-1:0] p00_r, p01_r, p11_r;
  logic signed [63:0]          p00_w, p01_w, p11_w;

  // per item work registers
  state_t             state_r, ret_r;
  logic signed [32:0] z_r [3];
  logic [1:0]         idx_r;
  logic signed [33:0] y_r;
  logic signed [63:0] s_r, t1_r, t2_r, acc_r;
  logic [127:0]       cmp_r;
  logic [2:0]         used_r, inval_r, outl_r;

  logic               out_tvalid_r;
  logic signed [31:0] out_h_r;
  logic [2:0]         out_used_r, out_inval_r, out_outl_r;

  // shared unit
  u_state_t           u_state_r;
  logic [63:0]        ma_r, mb_r, dv_r;
  logic [127:0]       prod_r;
  logic               neg_r, ovf_r;
  op_mode_t           mode_r;
  logic [5:0]         cnt_r;
  logic signed [63:0] u_res_r;

  logic               u_start, u_done;
  logic signed [63:0] op_a, op_b, op_d;
  op_mode_t           op_mode;

  logic [79:0]        pp;
  logic [64:0]        div_t;
  logic               div_ge;
  logic [63:0]        div_hi;
  logic [127:0]       sh_q;
  logic [63:0]        fin_mag;
  logic               fin_over;

  logic signed [32:0] z_sel;
  logic               z_ok, gate_pass;
  logic signed [63:0] s_calc;
  logic [127:0]       lhs;

  assign p00_w = 64'(p00_r);
  assign p01_w = 64'(p01_r);
  assign p11_w = 64'(p11_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_outl_r, out_inval_r, out_used_r, out_h_r};

  assign z_sel = z_r[idx_r];
  assign z_ok  = (z_sel > 33'(min_r)) && (z_sel < 33'(max_r));

  always_comb begin
    s_calc = 64'(satcov(sadd64(p00_w, meas_noise(idx_r))));
    if (s_calc < 64'sd1) s_calc = 64'sd1;
  end

  assign lhs       = prod_r << COV_FRAC;
  assign gate_pass = !(lhs > cmp_r);

  // operand selection for the shared unit
  always_comb begin
    u_start = 1'b0;
    op_a    = '0;
    op_b    = 64'(step_r);
    op_d    = s_r;
    op_mode = OP_SH;
    case (state_r)
      S_P1: begin u_start = 1'b1; op_a = 64'(v_r); end
      S_P2: begin u_start = 1'b1; op_a = p01_w; end
      S_P3: begin u_start = 1'b1; op_a = p11_w; end
      S_P4: begin u_start = 1'b1; op_a = u_res_r; end
      S_CHK: begin
        u_start = z_ok;
        op_mode = OP_RAW;
        op_a    = 64'(gate_r);
        op_b    = 64'(gate_r);
      end
      S_G1: begin
        u_start = 1'b1;
        op_mode = OP_RAW;
        op_a    = prod_r[63:0];
        op_b    = s_r;
      end
      S_G2: begin
        u_start = 1'b1;
        op_mode = OP_RAW;
        op_a    = 64'(y_r);
        op_b    = 64'(y_r);
      end
      S_G3: begin
        u_start = gate_pass;
        op_mode = OP_DIV;
        op_a    = p00_w;
        op_b    = 64'(y_r);
      end
      S_U1: begin u_start = 1'b1; op_mode = OP_DIV; op_a = p01_w; op_b = 64'(y_r); end
      S_U2: begin u_start = 1'b1; op_mode = OP_DIV; op_a = p01_w; op_b = p01_w; end
      S_U3: begin u_start = 1'b1; op_mode = OP_DIV; op_a = p00_w; op_b = p01_w; end
      S_U4: begin u_start = 1'b1; op_mode = OP_DIV; op_a = p00_w; op_b = p00_w; end
      default: ;
    endcase
  end

  // main sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      terrain_r    <= '0;
      gate_r       <= GATE_RST;
      min_r        <= MIN_RST;
      max_r        <= MAX_RST;
      step_r       <= STEP_RST;
      h_r          <= '0;
      v_r          <= '0;
      p00_r        <= satcov(COV_INIT_H);
      p01_r        <= '0;
      p11_r        <= satcov(COV_INIT_V);
      idx_r        <= '0;
      used_r       <= '0;
      inval_r      <= '0;
      outl_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_OUT) out_tvalid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_TERRAIN: terrain_r <= cfg_data;
          REG_GATE:    gate_r    <= cfg_data[23:0];
          REG_INIT: begin
            h_r    <= cfg_data;
            v_r    <= '0;
            p00_r  <= satcov(COV_INIT_H);
            p01_r  <= '0;
            p11_r  <= satcov(COV_INIT_V);
          end
          REG_MIN:     min_r  <= cfg_data;
          REG_MAX:     max_r  <= cfg_data;
          REG_STEP:    step_r <= cfg_data[23:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            z_r[0]  <= 33'(signed'(in_tdata[31:0])) - 33'(terrain_r);
            z_r[1]  <= 33'(signed'(in_tdata[63:32]));
            z_r[2]  <= 33'(signed'(in_tdata[95:64]));
            used_r  <= '0;
            inval_r <= '0;
            outl_r  <= '0;
            state_r <= S_P1;
          end
        end
        S_P1: begin ret_r <= S_P2; state_r <= S_WAIT; end
        S_P2: begin
          h_r     <= sat32(65'(h_r) + 65'(u_res_r));
          ret_r   <= S_P3;
          state_r <= S_WAIT;
        end
        S_P3: begin t1_r <= u_res_r; ret_r <= S_P4; state_r <= S_WAIT; end
        S_P4: begin t2_r <= u_res_r; ret_r <= S_P5; state_r <= S_WAIT; end
        S_P5: begin acc_r <= sadd64(p00_w, t1_r); state_r <= S_P6; end
        S_P6: begin acc_r <= sadd64(acc_r, t1_r); state_r <= S_P7; end
        S_P7: begin acc_r <= sadd64(acc_r, u_res_r); state_r <= S_P8; end
        S_P8: begin
          p00_r   <= satcov(sadd64(acc_r, PROC_NOISE));
          p01_r   <= satcov(sadd64(p01_w, t2_r));
          p11_r   <= satcov(sadd64(p11_w, PROC_NOISE));
          idx_r   <= '0;
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (!z_ok) begin
            inval_r[idx_r] <= 1'b1;
            state_r        <= S_NEXT;
          end else begin
            y_r     <= 34'(z_sel) - 34'(h_r);
            s_r     <= s_calc;
            ret_r   <= S_G1;
            state_r <= S_WAIT;
          end
        end
        S_G1: begin ret_r <= S_G2; state_r <= S_WAIT; end
        S_G2: begin cmp_r <= prod_r; ret_r <= S_G3; state_r <= S_WAIT; end
        S_G3: begin
          if (!gate_pass) begin
            outl_r[idx_r] <= 1'b1;
            state_r       <= S_NEXT;
          end else begin
            ret_r   <= S_U1;
            state_r <= S_WAIT;
          end
        end
        S_U1: begin
          h_r     <= sat32(65'(h_r) + 65'(sat32(65'(u_res_r))));
          ret_r   <= S_U2;
          state_r <= S_WAIT;
        end
        S_U2: begin
          v_r     <= sat32(65'(v_r) + 65'(sat32(65'(u_res_r))));
          ret_r   <= S_U3;
          state_r <= S_WAIT;
        end
        S_U3: begin
          p11_r   <= satcov(ssub64(p11_w, u_res_r));
          ret_r   <= S_U4;
          state_r <= S_WAIT;
        end
        S_U4: begin
          p01_r   <= satcov(ssub64(p01_w, u_res_r));
          ret_r   <= S_U5;
          state_r <= S_WAIT;
        end
        S_U5: begin
          p00_r         <= satcov(ssub64(p00_w, u_res_r));
          used_r[idx_r] <= 1'b1;
          state_r       <= S_NEXT;
        end
        S_NEXT: begin
          if (idx_r == 2'd2) begin
            state_r <= S_OUT;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_CHK;
          end
        end
        S_WAIT: begin
          if (u_done) state_r <= ret_r;
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_h_r      <= h_r;
            out_used_r   <= used_r;
            out_inval_r  <= inval_r;
            out_outl_r   <= outl_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // shared multiply / divide unit datapath
  assign pp     = ma_r * mb_r[63:48];
  assign div_t  = {prod_r[127:64], prod_r[63]};
  assign div_ge = div_t >= {1'b0, dv_r};
  assign div_hi = div_ge ? 64'(div_t - {1'b0, dv_r}) : div_t[63:0];
  assign sh_q   = prod_r >> FRAC_BITS;
  assign u_done = (u_state_r == U_FIN);

  always_comb begin
    if (mode_r == OP_DIV) begin
      fin_over = ovf_r | prod_r[63];
      fin_mag  = prod_r[63:0];
    end else begin
      fin_over = |sh_q[127:63];
      fin_mag  = sh_q[63:0];
    end
    if (fin_over) fin_mag = 64'h7fff_ffff_ffff_ffff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_state_r <= U_IDLE;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
    end else begin
      case (u_state_r)
        U_IDLE: begin
          if (u_start) begin
            ma_r      <= mag64(op_a);
            mb_r      <= mag64(op_b);
            neg_r     <= op_a[63] ^ op_b[63];
            mode_r    <= op_mode;
            dv_r      <= op_d;
            prod_r    <= '0;
            cnt_r     <= '0;
            ovf_r     <= 1'b0;
            u_state_r <= U_MUL;
          end
        end
        U_MUL: begin
          // 16 multiplier bits per cycle, top slice first
          prod_r <= (prod_r << 16) + 128'(pp);
          mb_r   <= mb_r << 16;
          if (cnt_r == 6'd3) begin
            cnt_r     <= '0;
            u_state_r <= (mode_r == OP_RAW) ? U_FIN : U_RND;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        U_RND: begin
          prod_r    <= prod_r + ((mode_r == OP_DIV) ? 128'(dv_r >> 1) : SH_RND);
          u_state_r <= (mode_r == OP_DIV) ? U_DIV : U_FIN;
        end
        U_DIV: begin
          // quotient that does not fit in 63 bits saturates
          if (cnt_r == 6'd0 && prod_r[127:64] >= dv_r) begin
            ovf_r     <= 1'b1;
            u_state_r <= U_FIN;
          end else begin
            prod_r <= {div_hi, prod_r[62:0], div_ge};
            cnt_r  <= cnt_r + 6'd1;
            if (cnt_r == 6'd63) u_state_r <= U_FIN;
          end
        end
        U_FIN: begin
          u_res_r   <= neg_r ? -signed'(fin_mag) : signed'(fin_mag);
          u_state_r <= U_IDLE;
        end
        default: u_state_r <= U_IDLE;
      endcase
    end
  end

endmodule

[tb/sv/hkf_checker.sv]
// checker for the height fusion filter: tracks config, predicts each result and compares
module hkf_checker
  import hkf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [95:0]      in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [47:0]      out_tdata,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data,
  output int               mismatches,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] height;
    logic [2:0]         used;
    logic [2:0]         invalid;
    logic [2:0]         outlier;
  } fusion_result_t;

  localparam logic signed [63:0] COV_HI = (64'sd1 <<< 55) - 64'sd1;
  localparam logic signed [63:0] COV_LO = -(64'sd1 <<< 55);
  localparam logic [127:0]       Q_MAX  = 128'h7fff_ffff_ffff_ffff;

  fusion_result_t fused_q[$];

  logic signed [63:0] terrain, init_h, win_lo, win_hi;
  logic [23:0]        gate, dt;
  logic signed [63:0] h_est, v_est, p_hh, p_hv, p_vv;

  function automatic logic [63:0] absval(input logic signed [63:0] a);
    return a[63] ? ~a + 64'd1 : a;
  endfunction

  function automatic logic signed [63:0] signed_clamp(input logic [127:0] q, input logic neg);
    logic [63:0] m;
    m = (q > Q_MAX) ? Q_MAX[63:0] : q[63:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // round(a*b / 2^n), ties away from zero
  function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                        input logic signed [63:0] b,
                                                        input int n);
    logic [127:0] p;
    p = 128'(absval(a)) * 128'(absval(b)) + (128'd1 << (n - 1));
    return signed_clamp(p >> n, a[63] != b[63]);
  endfunction

  // round(a*b / d), d positive
  function automatic logic signed [63:0] scaled_ratio(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input logic signed [63:0] d);
    logic [127:0] p;
    p = 128'(absval(a)) * 128'(absval(b)) + 128'(d[63:1]);
    return signed_clamp(p / 128'(d), a[63] != b[63]);
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] cov_clip(input logic signed [63:0] x);
    return x > COV_HI ? COV_HI : (x < COV_LO ? COV_LO : x);
  endfunction

  function automatic logic signed [63:0] height_clip(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic void reload_state();
    h_est = init_h;
    v_est = 0;
    p_hh  = cov_clip(COV_INIT_H);
    p_hv  = 0;
    p_vv  = cov_clip(COV_INIT_V);
  endfunction

  function automatic fusion_result_t fuse_readings(input logic [95:0] d);
    fusion_result_t     r;
    logic signed [63:0] z[3];
    logic signed [63:0] noise[3];
    logic signed [63:0] hv_dt, vv_dt, y, s, a, b, c;
    logic [127:0]       lhs, rhs;
    noise[0] = 64'sd67108864;
    noise[1] = 64'sd16777216;
    noise[2] = 64'sd37748736;
    z[0] = 64'($signed(d[31:0])) - terrain;
    z[1] = 64'($signed(d[63:32]));
    z[2] = 64'($signed(d[95:64]));
    r = '0;
    h_est = height_clip(h_est + scaled_product(v_est, 64'(dt), 16));
    hv_dt = scaled_product(p_hv, 64'(dt), 16);
    vv_dt = scaled_product(p_vv, 64'(dt), 16);
    p_hh = cov_clip(add_sat(add_sat(add_sat(add_sat(p_hh, hv_dt), hv_dt),
                                    scaled_product(vv_dt, 64'(dt), 16)), PROC_NOISE));
    p_hv = cov_clip(add_sat(p_hv, vv_dt));
    p_vv = cov_clip(add_sat(p_vv, PROC_NOISE));
    for (int i = 0; i < 3; i++) begin
      if (!(z[i] > win_lo && z[i] < win_hi)) begin
        r.invalid[i] = 1'b1;
        continue;
      end
      y = z[i] - h_est;
      s = cov_clip(add_sat(p_hh, noise[i]));
      if (s < 1) s = 1;
      lhs = (128'(absval(y)) * 128'(absval(y))) << 24;
      rhs = 128'(64'(gate) * 64'(gate)) * 128'(s);
      if (lhs > rhs) begin
        r.outlier[i] = 1'b1;
        continue;
      end
      a = p_hh; b = p_hv; c = p_vv;
      h_est = height_clip(h_est + height_clip(scaled_ratio(a, y, s)));
      v_est = height_clip(v_est + height_clip(scaled_ratio(b, y, s)));
      p_hh = cov_clip(add_sat(a, -scaled_ratio(a, a, s)));
      p_hv = cov_clip(add_sat(b, -scaled_ratio(a, b, s)));
      p_vv = cov_clip(add_sat(c, -scaled_ratio(b, b, s)));
      r.used[i] = 1'b1;
    end
    r.height = h_est[31:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
  end

  assign pending = fused_q.size();

  always @(posedge clk) begin
    fusion_result_t e;
    if (!rst_n) begin
      terrain = 0; gate = GATE_RST; init_h = 0;
      win_lo = 64'(MIN_RST); win_hi = 64'(MAX_RST); dt = STEP_RST;
      reload_state();
      fused_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TERRAIN: terrain = 64'($signed(cfg_data));
          REG_GATE:    gate = cfg_data[23:0];
          REG_INIT: begin
            init_h = 64'($signed(cfg_data));
            reload_state();
          end
          REG_MIN:     win_lo = 64'($signed(cfg_data));
          REG_MAX:     win_hi = 64'($signed(cfg_data));
          REG_STEP:    dt = cfg_data[23:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) fused_q.push_back(fuse_readings(in_tdata));
      if (out_tvalid && out_tready) begin
        if (fused_q.size() == 0) begin
          report("result transfer with nothing expected", 64'(out_tdata), 0);
        end else begin
          e = fused_q.pop_front();
          if (out_tdata[31:0] != e.height) report("fused height", 64'(out_tdata[31:0]), 64'(e.height));
          if (out_tdata[34:32] != e.used) report("used_mask", 64'(out_tdata[34:32]), 64'(e.used));
          if (out_tdata[37:35] != e.invalid) report("invalid_mask", 64'(out_tdata[37:35]), 64'(e.invalid));
          if (out_tdata[40:38] != e.outlier) report("outlier_mask", 64'(out_tdata[40:38]), 64'(e.outlier));
          if (out_tdata[47:41] != 0) report("zero fill", 64'(out_tdata[47:41]), 0);
        end
      end
    end
  end
endmodule

[tb/sv/testbench.sv]
// top of the height fusion testbench: clock, reset, stimulus and verdict
module testbench
  import hkf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [95:0]      in_tdata = '0;   // gps_altitude, alt1_height, alt2_height
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [47:0]      out_tdata;       // fused height, used, invalid, outlier masks, zero fill
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [31:0]      cfg_data = '0;
  int               mismatches, pending;
  int               gap_max = 11;
  int               stall_max = 11;
  logic signed [31:0] track_h, cur_terrain;

  always #2 clk = ~clk;

  height_kalman_fusion dut (.*);

  hkf_checker u_checker (.*);

  task automatic send_readings(input logic signed [31:0] gps, input logic signed [31:0] a1,
                               input logic signed [31:0] a2);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {a2, a1, gps};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // drain every result, then let the block settle before touching config
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] jitter(input int span);
    return $signed(32'($urandom_range(0, 2 * span))) - span;
  endfunction

  task automatic random_reading_set();
    int mode;
    logic signed [31:0] g, a1, a2;
    mode = $urandom_range(0, 9);
    track_h = track_h + jitter(32768);
    g  = track_h + cur_terrain + jitter(4 * 65536);
    a1 = track_h + jitter(65536);
    a2 = track_h + jitter(2 * 65536);
    case (mode)
      0: begin g = $urandom; a1 = $urandom; a2 = $urandom; end
      1: begin
        g  = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        a1 = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      end
      2: a2 = a2 + jitter(1000 * 65536);
      3: g = g + jitter(5000 * 65536);
      default: ;
    endcase
    send_readings(g, a1, a2);
  endtask

  // receiver: random stalls, with whole stretches of none
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #60_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [31:0] v;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    track_h = 0;
    cur_terrain = 0;

    // directed: extremes, window edges, a clean track, outliers
    send_readings(0, 0, 0);
    send_readings(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_readings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_readings(MIN_RST, MIN_RST + 1, MAX_RST - 1);
    send_readings(MAX_RST, MAX_RST - 1, MIN_RST);
    for (int i = 0; i < 6; i++) send_readings(65536 * 10, 65536 * 10, 65536 * 10);
    send_readings(65536 * 10, 65536 * 900, 65536 * 10);
    send_readings(65536 * 9000, 65536 * 11, 65536 * 11);
    drain();

    // gps against terrain extremes, gate and step at zero and at full scale, unused indexes
    write_reg(REG_TERRAIN, 32'h8000_0000);
    write_reg(REG_GATE, 0);
    write_reg(REG_STEP, 0);
    write_reg(3'd6, $urandom);
    write_reg(3'd7, $urandom);
    cfg_we <= 1'b0;
    send_readings(32'h7fff_ffff, 0, 65536);
    send_readings(0, 0, 0);
    send_readings(32'h8000_0000, 32'h7fff_ffff, 5);
    drain();
    write_reg(REG_TERRAIN, 32'h7fff_ffff);
    write_reg(REG_GATE, 24'hff_ffff);
    write_reg(REG_STEP, 24'hff_ffff);
    cfg_we <= 1'b0;
    send_readings(32'h8000_0000, 65536 * 50, 32'h8000_0000);
    send_readings(0, 32'h7fff_ffff, 65536);
    send_readings(32'h8000_0000, 65536 * 50, 65536 * 60);
    drain();

    // random phases, each with its own settings
    for (int ph = 0; ph < 9; ph++) begin
      cur_terrain = (ph % 3 == 0) ? 0 : jitter(500 * 65536);
      write_reg(REG_TERRAIN, cur_terrain);
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = 24'hff_ffff;
        2: v = 1;
        default: v = GATE_RST + $urandom_range(0, 5 * 65536);
      endcase
      if (ph == 8) v = GATE_RST;
      write_reg(REG_GATE, v);
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = 24'hff_ffff;
        2: v = 1;
        default: v = $urandom_range(1, 65536);
      endcase
      if (ph == 8) v = STEP_RST;
      write_reg(REG_STEP, v);
      case (ph % 4)
        0: begin write_reg(REG_MIN, MIN_RST); write_reg(REG_MAX, MAX_RST); end
        1: begin write_reg(REG_MIN, 32'h8000_0000); write_reg(REG_MAX, 32'h7fff_ffff); end
        2: begin write_reg(REG_MIN, 65536 * 20); write_reg(REG_MAX, 65536 * 400); end
        default: begin write_reg(REG_MIN, MAX_RST); write_reg(REG_MAX, MIN_RST); end
      endcase
      if (ph != 5) begin
        track_h = jitter(300 * 65536) + 65536 * 200;
        write_reg(REG_INIT, track_h);
      end
      cfg_we <= 1'b0;
      gap_max = (ph == 2) ? 0 : 11;
      stall_max = (ph == 4) ? 0 : 11;
      for (int n = 0; n < 200; n++) random_reading_set();
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
